>>> rtl/piopc_pkg.sv
// Package for the two-port parallel I/O controller.
// Holds operation and mode codes, control word codes and reset constants.
// No dependencies.
package piopc_pkg;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_PIN    = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PM_OUT    = 2'd0,
    PM_IN     = 2'd1,
    PM_BIDIR  = 2'd2,
    PM_BITCTL = 2'd3
  } mode_t;

  localparam logic [7:0] CTRL_READ_VALUE = 8'h43;
  localparam logic [7:0] PIN_RESET       = 8'hF0;
  localparam logic [7:0] DIR_RESET       = 8'hFF;
  localparam logic [7:0] MASK_ALL        = 8'hFF;

  // low nibble codes of control words
  localparam logic [3:0] CW_MODE    = 4'hF;
  localparam logic [3:0] CW_INT_CTL = 4'h7;
  localparam logic [3:0] CW_INT_EN  = 4'h3;

endpackage

>>> rtl/parallel_io_port_controller_core.sv
// Top level of the two-port parallel I/O controller.
// Decodes bus reads, bus writes and pin events; depends on piopc_pkg.
//
// channel | handshake            | payload
// --------+----------------------+-------------------------------------------
// in      | in_valid / in_ready  | operation, port_sel, control_sel,
//         |                      | data_value, pin_index
// out     | out_valid / out_ready| read_data, interrupt_request,
//         |                      | interrupt_vector, port_{a,b}_pins,
//         |                      | port_{a,b}_direction
//
// One transaction per cycle while out_ready is high; the result appears in the cycle after acceptance.
// Port state is updated at the accepting edge from one level of decode logic.
// The result register is the only stage: in_ready is low only while it holds
// a result that out_ready has not taken.
// rst clears all port state to its reset values and empties the result register.
module parallel_io_port_controller_core
  import piopc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic       port_sel,
  input  logic       control_sel,
  input  logic [7:0] data_value,
  input  logic [2:0] pin_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       interrupt_request,
  output logic [7:0] interrupt_vector,
  output logic [7:0] port_a_pins,
  output logic [7:0] port_b_pins,
  output logic [7:0] port_a_direction,
  output logic [7:0] port_b_direction
);

  // per-port state
  logic [7:0] pins      [2];
  logic [7:0] dirs      [2];
  mode_t      mode      [2];
  logic [7:0] vector    [2];
  logic       irq_en    [2];
  logic [7:0] mon_mask  [2];
  logic       and_mode  [2];
  logic       act_high  [2];
  logic       mask_pend [2];
  logic       dir_pend  [2];

  // selected port, current and next
  logic [7:0] cur_pins, cur_dirs, cur_vector, cur_mask;
  mode_t      cur_mode;
  logic       cur_irq_en, cur_and, cur_act_high;
  logic [7:0] pins_next, dirs_next, vector_next, mask_next;
  mode_t      mode_next;
  logic       irq_en_next, and_next, act_high_next, mask_pend_next, dir_pend_next;

  logic       accept;
  logic [7:0] pin_bit;
  logic       pin_high;
  logic [7:0] watched;
  logic [7:0] active_lvl;
  logic [7:0] rd_next;
  logic       irq_next;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    cur_pins     = pins[port_sel];
    cur_dirs     = dirs[port_sel];
    cur_mode     = mode[port_sel];
    cur_vector   = vector[port_sel];
    cur_irq_en   = irq_en[port_sel];
    cur_mask     = mon_mask[port_sel];
    cur_and      = and_mode[port_sel];
    cur_act_high = act_high[port_sel];

    pins_next      = cur_pins;
    dirs_next      = cur_dirs;
    mode_next      = cur_mode;
    vector_next    = cur_vector;
    irq_en_next    = cur_irq_en;
    mask_next      = cur_mask;
    and_next       = cur_and;
    act_high_next  = cur_act_high;
    mask_pend_next = mask_pend[port_sel];
    dir_pend_next  = dir_pend[port_sel];
    rd_next        = '0;
    irq_next       = 1'b0;

    pin_bit    = 8'd1 << pin_index;
    pin_high   = |data_value;
    watched    = ~cur_mask;
    active_lvl = cur_act_high ? MASK_ALL : 8'h00;

    case (op_t'(operation))
      OP_READ: begin
        rd_next = control_sel ? CTRL_READ_VALUE : cur_pins;
      end
      OP_WRITE: begin
        if (control_sel) begin
          if (dir_pend[port_sel]) begin
            dir_pend_next = 1'b0;
            dirs_next     = data_value;
          end else if (mask_pend[port_sel]) begin
            mask_pend_next = 1'b0;
            mask_next      = data_value;
          end else if (data_value[3:0] == CW_MODE) begin
            mode_next     = mode_t'(data_value[7:6]);
            dir_pend_next = (mode_t'(data_value[7:6]) == PM_BITCTL);
          end else if (data_value[3:0] == CW_INT_CTL) begin
            mask_pend_next = data_value[4];
            act_high_next  = data_value[5];
            and_next       = data_value[6];
            irq_en_next    = data_value[7];
            if (data_value[4]) begin
              mask_next = MASK_ALL;
            end
          end else if (data_value[3:0] == CW_INT_EN) begin
            irq_en_next = data_value[7];
          end else if (!data_value[0]) begin
            vector_next = data_value;
          end
        end else begin
          if (cur_mode == PM_BITCTL) begin
            pins_next = (cur_pins & cur_dirs) | (data_value & ~cur_dirs);
          end else if (cur_mode != PM_IN) begin
            pins_next = data_value;
          end
        end
      end
      OP_PIN: begin
        pins_next = pin_high ? (cur_pins | pin_bit) : (cur_pins & ~pin_bit);
        if (cur_irq_en && (pins_next != cur_pins) && (cur_mode != PM_OUT)) begin
          if (cur_mode != PM_BITCTL) begin
            irq_next = 1'b1;
          end else if (((cur_mask & pin_bit) == '0) && (cur_act_high == pin_high)) begin
            // AND mode: every monitored pin must sit at the active level
            irq_next = !cur_and || ((pins_next & watched) == (active_lvl & watched));
          end
        end
      end
      default: begin
      end
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        pins[i]      <= PIN_RESET;
        dirs[i]      <= DIR_RESET;
        mode[i]      <= PM_OUT;
        vector[i]    <= '0;
        irq_en[i]    <= 1'b0;
        mon_mask[i]  <= '0;
        and_mode[i]  <= 1'b1;
        act_high[i]  <= 1'b0;
        mask_pend[i] <= 1'b0;
        dir_pend[i]  <= 1'b0;
      end
    end else if (accept) begin
      pins[port_sel]      <= pins_next;
      dirs[port_sel]      <= dirs_next;
      mode[port_sel]      <= mode_next;
      vector[port_sel]    <= vector_next;
      irq_en[port_sel]    <= irq_en_next;
      mon_mask[port_sel]  <= mask_next;
      and_mode[port_sel]  <= and_next;
      act_high[port_sel]  <= act_high_next;
      mask_pend[port_sel] <= mask_pend_next;
      dir_pend[port_sel]  <= dir_pend_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data         <= rd_next;
      interrupt_request <= irq_next;
      interrupt_vector  <= irq_next ? cur_vector : 8'h00;
      port_a_pins       <= port_sel ? pins[0] : pins_next;
      port_b_pins       <= port_sel ? pins_next : pins[1];
      port_a_direction  <= port_sel ? dirs[0] : dirs_next;
      port_b_direction  <= port_sel ? dirs_next : dirs[1];
    end
  end

  // a port never waits for a direction word and a mask word at once
  a_pend_excl: assert property (@(posedge clk) disable iff (rst)
    !(dir_pend[0] && mask_pend[0]) && !(dir_pend[1] && mask_pend[1]))
    else $error("direction and mask word both pending");

  // direction word is only awaited in bit-control mode
  a_dir_pend_mode: assert property (@(posedge clk) disable iff (rst)
    (!dir_pend[0] || mode[0] == PM_BITCTL) && (!dir_pend[1] || mode[1] == PM_BITCTL))
    else $error("direction word pending outside bit-control mode");

  // an output-mode port never interrupts
  a_no_irq_output: assert property (@(posedge clk) disable iff (rst)
    accept && cur_mode == PM_OUT |=> !interrupt_request)
    else $error("interrupt raised in output mode");

  // control read returns the fixed status byte
  a_ctrl_read: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_READ && control_sel |=> read_data == CTRL_READ_VALUE)
    else $error("control read value wrong");

  // a request only comes with a pin event, never with a read value
  a_irq_no_rd: assert property (@(posedge clk) disable iff (rst)
    accept && operation != OP_PIN |=> !interrupt_request && interrupt_vector == 8'h00)
    else $error("interrupt on a bus access");

endmodule
